### rtl/chip8_instruction_execute_unit_core_defines.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef CHIP8_INSTRUCTION_EXECUTE_UNIT_CORE_DEFINES_SVH
`define CHIP8_INSTRUCTION_EXECUTE_UNIT_CORE_DEFINES_SVH
// clocked implication, disabled while the active-low reset is low
`define C8_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define C8_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### rtl/c8eu_pkg.sv
// Package for the CHIP-8 execute unit: codes, widths, control structs.
// No dependencies.
package c8eu_pkg;
    localparam int STACK_DEPTH = 16;
    localparam int ADDR_BITS   = 12;
    localparam int SP_BITS     = $clog2(STACK_DEPTH + 1);
    localparam int SI_BITS     = $clog2(STACK_DEPTH);

    localparam logic [1:0] CMD_EXEC    = 2'd0;
    localparam logic [1:0] CMD_LOAD    = 2'd1;
    localparam logic [1:0] CMD_COLLIDE = 2'd2;

    localparam logic [2:0] KIND_STATUS = 3'd0;
    localparam logic [2:0] KIND_WRITE  = 3'd1;
    localparam logic [2:0] KIND_READ   = 3'd2;
    localparam logic [2:0] KIND_CLEAR  = 3'd3;
    localparam logic [2:0] KIND_DRAW   = 3'd4;

    localparam logic [1:0] REG_START  = 2'd0;
    localparam logic [1:0] REG_FONT   = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE, ST_EXEC, ST_BURST, ST_BCD, ST_OUT, ST_STATUS
    } t_state;

    typedef struct packed {
        logic       exec;      // run one input beat's register updates
        logic       burst_clr; // reset burst index
        logic       burst_inc;
        logic       emit;      // load output register with current item
        logic [2:0] emit_kind; // used with emit
    } t_cmd;

    typedef struct packed {
        logic       burst;     // opcode is Fx55 or Fx65
        logic       bcd;       // Fx33
        logic       single;    // one side-effect item (clear or draw)
        logic       burst_end; // burst index reached x
        logic       bcd_end;
        logic [2:0] single_kind;
        logic [2:0] burst_kind;
    } t_stat;
endpackage

### rtl/c8eu_stream_if.sv
// Valid/ready channel carrying a packed payload.
// Depends on nothing.
interface c8eu_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

### rtl/c8eu_ctrl.sv
// Sequencer for the execute unit: accepts beats, steps bursts, emits items.
// Depends on c8eu_pkg.
module c8eu_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  c8eu_pkg::t_stat  i_stat,
    output c8eu_pkg::t_cmd   o_cmd,
    output logic             o_last
);
    import c8eu_pkg::*;

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    logic   r_last, n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_last  = r_last;
        o_cmd   = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                // commit state first; emitting opcodes leave V and I untouched,
                // so every beat of the command carries the updated status
                o_cmd.exec = 1'b1;
                o_cmd.burst_clr = 1'b1;
                if (i_stat.burst) n_state = ST_BURST;
                else if (i_stat.bcd) n_state = ST_BCD;
                else if (i_stat.single) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_kind = i_stat.single_kind;
                    n_last = 1'b0;
                    n_ret = ST_STATUS;
                    n_state = ST_OUT;
                end else n_state = ST_STATUS;
            end
            ST_BURST, ST_BCD: begin
                o_cmd.emit = 1'b1;
                o_cmd.emit_kind = (r_state == ST_BCD) ? KIND_WRITE : i_stat.burst_kind;
                o_cmd.burst_inc = 1'b1;
                n_last = 1'b0;
                n_ret = ((r_state == ST_BURST) ? i_stat.burst_end : i_stat.bcd_end)
                        ? ST_STATUS : r_state;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = r_ret;
                    if (r_last) n_state = ST_IDLE;
                end
            end
            ST_STATUS: begin
                // show status beat
                o_cmd.emit = 1'b1;
                o_cmd.emit_kind = KIND_STATUS;
                n_last = 1'b1;
                n_state = ST_OUT;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_last = r_last;
endmodule

### rtl/c8eu_datapath.sv
// Register file, stack, timers and output register of the execute unit.
// Depends on c8eu_pkg.
module c8eu_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [11:0]          i_cfg_data,
    input  logic                 i_take,
    input  logic [1:0]           i_command,
    input  logic [15:0]          i_opcode,
    input  logic [15:0]          i_keys_down,
    input  logic [7:0]           i_random_byte,
    input  logic [3:0]           i_reply_register,
    input  logic [7:0]           i_reply_data,
    input  c8eu_pkg::t_cmd       i_cmd,
    output c8eu_pkg::t_stat      o_stat,
    output logic [2:0]           o_kind,
    output logic [11:0]          o_address,
    output logic [7:0]           o_payload,
    output logic [7:0]           o_sprite_x,
    output logic [7:0]           o_sprite_y,
    output logic [11:0]          o_next_pc,
    output logic                 o_fault,
    output logic                 o_sound_on
);
    import c8eu_pkg::*;

    logic [11:0] r_font;
    logic [3:0]  r_height;
    logic [1:0]  r_cmd;
    logic [15:0] r_op, r_keys;
    logic [7:0]  r_rnd, r_rdata;
    logic [3:0]  r_rreg;
    logic [7:0]  r_v [16];
    logic [15:0] r_i;
    logic [ADDR_BITS-1:0] r_pc;
    logic [SP_BITS-1:0]   r_sp;
    logic [ADDR_BITS-1:0] r_stk [STACK_DEPTH];
    logic [7:0]  r_dt, r_st;
    logic        r_fault;
    logic [3:0]  r_bi;
    logic [2:0]  r_kind;
    logic [11:0] r_addr;
    logic [7:0]  r_pay, r_sx, r_sy;

    logic [3:0] x, y, n;
    logic [7:0] kk, vx, vy;
    assign x = r_op[11:8];
    assign y = r_op[7:4];
    assign n = r_op[3:0];
    assign kk = r_op[7:0];
    assign vx = r_v[x];
    assign vy = r_v[y];

    logic is_exec;
    assign is_exec = (r_cmd == CMD_EXEC);

    always_comb begin
        o_stat = '0;
        o_stat.burst_kind = (kk == 8'h55) ? KIND_WRITE : KIND_READ;
        o_stat.burst_end = (r_bi == x);
        o_stat.bcd_end = (r_bi == 4'd2);
        if (is_exec) begin
            if (r_op[15:12] == 4'hF && (kk == 8'h55 || kk == 8'h65)) o_stat.burst = 1'b1;
            if (r_op[15:12] == 4'hF && kk == 8'h33) o_stat.bcd = 1'b1;
            if (r_op == 16'h00E0) begin
                o_stat.single = 1'b1;
                o_stat.single_kind = KIND_CLEAR;
            end
            if (r_op[15:12] == 4'hD) begin
                o_stat.single = 1'b1;
                o_stat.single_kind = KIND_DRAW;
            end
        end
    end

    // BCD digits of Vx; tens by reciprocal multiply, exact below 100
    logic [3:0]  hund, tens, ones;
    logic [7:0]  rem1;
    logic [15:0] tens_prod;
    always_comb begin
        hund = (vx >= 8'd200) ? 4'd2 : (vx >= 8'd100) ? 4'd1 : 4'd0;
        rem1 = vx - ({4'd0, hund} * 8'd100);
        tens_prod = 16'(rem1) * 16'd205;
        tens = tens_prod[14:11];
        ones = 4'(rem1 - ({4'd0, tens} * 8'd10));
    end

    logic [15:0] ioff;
    assign ioff = r_i + 16'(r_bi);

    logic [ADDR_BITS-1:0] pc2, nxt;
    logic [15:0] font_addr;
    logic        down, f_set, push, pop;
    logic [7:0]  dt_new;
    logic        wv, wf;
    logic [7:0]  vval, fval;
    logic [15:0] ival;
    logic        wi;
    logic [8:0]  sum;
    always_comb begin
        pc2 = r_pc + ADDR_BITS'(2);
        nxt = pc2;
        font_addr = 16'(r_font) + 16'({4'd0, vx[3:0]} * {4'd0, r_height});
        down = r_keys[vx[3:0]];
        f_set = 1'b0; push = 1'b0; pop = 1'b0;
        dt_new = r_dt;
        wv = 1'b0; wf = 1'b0; vval = '0; fval = '0; wi = 1'b0; ival = r_i;
        sum = {1'b0, vx} + {1'b0, vy};
        case (r_op[15:12])
            4'h0: if (r_op == 16'h00EE) begin
                if (r_sp == '0) f_set = 1'b1;
                else begin pop = 1'b1; nxt = r_stk[SI_BITS'(r_sp - 1'b1)]; end
            end
            4'h1: nxt = ADDR_BITS'(r_op[11:0]);
            4'h2: begin
                if (r_sp >= SP_BITS'(STACK_DEPTH)) f_set = 1'b1;
                else push = 1'b1;
                nxt = ADDR_BITS'(r_op[11:0]);
            end
            4'h3: if (vx == kk) nxt = r_pc + ADDR_BITS'(4);
            4'h4: if (vx != kk) nxt = r_pc + ADDR_BITS'(4);
            4'h5: if (vx == vy) nxt = r_pc + ADDR_BITS'(4);
            4'h6: begin wv = 1'b1; vval = kk; end
            4'h7: begin wv = 1'b1; vval = vx + kk; end
            4'h8: case (n)
                4'h0: begin wv = 1'b1; vval = vy; end
                4'h1: begin wv = 1'b1; vval = vx | vy; end
                4'h2: begin wv = 1'b1; vval = vx & vy; end
                4'h3: begin wv = 1'b1; vval = vx ^ vy; end
                4'h4: begin wv = 1'b1; wf = 1'b1; vval = sum[7:0]; fval = {7'd0, sum[8]}; end
                4'h5: begin wv = 1'b1; wf = 1'b1; vval = vx - vy; fval = {7'd0, vx > vy}; end
                4'h6: begin wv = 1'b1; wf = 1'b1; vval = vx >> 1; fval = {7'd0, vx[0]}; end
                4'h7: begin wv = 1'b1; wf = 1'b1; vval = vy - vx; fval = {7'd0, vy > vx}; end
                4'hE: begin wv = 1'b1; wf = 1'b1; vval = vx << 1; fval = {7'd0, vx[7]}; end
                default: f_set = 1'b1;
            endcase
            4'h9: if (vx != vy) nxt = r_pc + ADDR_BITS'(4);
            4'hA: begin wi = 1'b1; ival = {4'd0, r_op[11:0]}; end
            4'hB: nxt = ADDR_BITS'(r_op[11:0]) + ADDR_BITS'(r_v[0]);
            4'hC: begin wv = 1'b1; vval = r_rnd & kk; end
            4'hD: ;
            4'hE: begin
                if (kk == 8'h9E) begin if (down) nxt = r_pc + ADDR_BITS'(4); end
                else if (kk == 8'hA1) begin if (!down) nxt = r_pc + ADDR_BITS'(4); end
                else f_set = 1'b1;
            end
            default: case (kk)
                8'h07: begin wv = 1'b1; vval = r_dt; end
                8'h0A, 8'h18, 8'h33, 8'h55, 8'h65: ;
                8'h15: dt_new = vx;
                8'h1E: begin wi = 1'b1; ival = r_i + 16'(vx); end
                8'h29: begin wi = 1'b1; ival = font_addr; end
                default: f_set = 1'b1;
            endcase
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_font <= 12'd80; r_height <= 4'd5;
            for (int k = 0; k < 16; k++) r_v[k] <= '0;
            for (int k = 0; k < STACK_DEPTH; k++) r_stk[k] <= '0;
            r_i <= '0; r_pc <= ADDR_BITS'(12'd512); r_sp <= '0;
            r_dt <= '0; r_st <= '0; r_fault <= 1'b0; r_bi <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    // start address only applies at reset, which always loads 512
                    REG_START:  ;
                    REG_FONT:   r_font   <= i_cfg_data;
                    REG_HEIGHT: r_height <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_cmd.burst_clr) r_bi <= '0;
            else if (i_cmd.burst_inc) r_bi <= r_bi + 4'd1;
            if (i_cmd.exec) begin
                if (r_cmd == CMD_LOAD) r_v[r_rreg] <= r_rdata;
                else if (r_cmd == CMD_COLLIDE) r_v[15] <= {7'd0, r_rdata != 8'd0};
                else if (is_exec) begin
                    // flag wins when x is VF
                    if (wv && !(wf && x == 4'hF)) r_v[x] <= vval;
                    if (wf) r_v[15] <= fval;
                    if (wi) r_i <= ival;
                    if (f_set) r_fault <= 1'b1;
                    if (push) begin
                        r_stk[SI_BITS'(r_sp)] <= pc2;
                        r_sp <= r_sp + 1'b1;
                    end
                    if (pop) r_sp <= r_sp - 1'b1;
                    r_pc <= nxt;
                    r_dt <= (dt_new != 0) ? dt_new - 8'd1 : 8'd0;
                    if (r_op[15:12] == 4'hF && kk == 8'h18)
                        r_st <= (vx != 0) ? vx - 8'd1 : 8'd0;
                    else if (r_st != 0) r_st <= r_st - 8'd1;
                end
            end
        end
    end

    // capture accepted beat; load the output register on emit
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_cmd <= i_command; r_op <= i_opcode; r_keys <= i_keys_down;
            r_rnd <= i_random_byte; r_rreg <= i_reply_register; r_rdata <= i_reply_data;
        end
        if (i_cmd.emit) begin
            r_kind <= i_cmd.emit_kind;
            case (i_cmd.emit_kind)
                KIND_DRAW: begin
                    r_addr <= r_i[11:0]; r_pay <= {4'd0, n}; r_sx <= vx; r_sy <= vy;
                end
                KIND_WRITE: begin
                    r_addr <= ioff[11:0]; r_sx <= '0; r_sy <= '0;
                    if (kk == 8'h33)
                        r_pay <= {4'd0, (r_bi == 4'd0) ? hund : (r_bi == 4'd1) ? tens : ones};
                    else r_pay <= r_v[r_bi];
                end
                KIND_READ: begin
                    r_addr <= ioff[11:0]; r_pay <= {4'd0, r_bi}; r_sx <= '0; r_sy <= '0;
                end
                default: begin
                    r_addr <= '0; r_pay <= '0; r_sx <= '0; r_sy <= '0;
                end
            endcase
        end
    end

    assign o_kind = r_kind;
    assign o_address = r_addr;
    assign o_payload = r_pay;
    assign o_sprite_x = r_sx;
    assign o_sprite_y = r_sy;
    assign o_next_pc = 12'(r_pc);
    assign o_fault = r_fault;
    assign o_sound_on = (r_st != 0);
endmodule

### rtl/chip8_instruction_execute_unit_core.sv
// CHIP-8 instruction execute unit, top level.
// Uses c8eu_pkg, c8eu_stream_if, c8eu_ctrl and c8eu_datapath.
//
// Input channel: one beat per command (opcode execute, load reply or
// collision reply). Output channel: the side-effect beats of that command
// (memory write, read request, clear, draw) and a final status beat with
// last set; every beat carries next_pc, fault and sound_on after the command.
// Sequence: the accepted beat executes in ST_EXEC; each side-effect item (a
// clear or draw, or each BCD or burst item from the burst sequencer, one
// item per visit of the output register) then passes through the output
// register, and the status beat follows. Fx55/Fx65 with x = 15 give 16 items.
// One command is in flight at a time; the next beat is accepted once the
// status beat is taken.
// Reset clears V, I, the stack, the fault flag and the timers; the program counter
// loads 512 and ignores the cfg start address. A stalled receiver holds the current
// output beat and the sequencer waits. Configuration is written through the cfg port
// while the unit is idle; the user must ensure that, the unit does not enforce it.
module chip8_instruction_execute_unit_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,
    c8eu_stream_if.sink   in_ch,
    c8eu_stream_if.source out_ch
);
    import c8eu_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  last, take;
    logic [2:0] kind;
    logic [11:0] addr, pc;
    logic [7:0] pay, sx, sy;
    logic fault, snd;

    assign take = in_ch.valid & in_ch.ready;

    c8eu_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_stat(stat), .o_cmd(cmd), .o_last(last)
    );

    // payload order: command, opcode, keys_down, random_byte, reply_register, reply_data
    c8eu_datapath u_dp (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_take(take),
        .i_command(in_ch.data[53:52]), .i_opcode(in_ch.data[51:36]),
        .i_keys_down(in_ch.data[35:20]), .i_random_byte(in_ch.data[19:12]),
        .i_reply_register(in_ch.data[11:8]), .i_reply_data(in_ch.data[7:0]),
        .i_cmd(cmd), .o_stat(stat),
        .o_kind(kind), .o_address(addr), .o_payload(pay),
        .o_sprite_x(sx), .o_sprite_y(sy), .o_next_pc(pc),
        .o_fault(fault), .o_sound_on(snd)
    );

    assign out_ch.data = {kind, addr, pay, sx, sy, pc, fault, snd, last};
endmodule

### rtl/c8eu_checker.sv
// Port-level checker for the execute unit, bound to the top level.
// Depends on the defines header, c8eu_pkg and c8eu_stream_if.
`include "chip8_instruction_execute_unit_core_defines.svh"
module c8eu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [53:0] out_data
);
    import c8eu_pkg::*;

    // no new command while an output beat is offered
    `C8_ASSERT_IMP(a_excl, i_clk, i_rst_n, out_valid, !in_ready, "ready during output")
    // after acceptance, no input ready until status taken
    `C8_ASSERT_NEXT(a_busy, i_clk, i_rst_n, in_valid && in_ready, !in_ready, "ready after accept")
    // a status beat is always last
    `C8_ASSERT_IMP(a_stat, i_clk, i_rst_n, out_valid && out_data[53:51] == KIND_STATUS, out_data[0], "status not last")
    // stalled beat holds
    `C8_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled beat changed")
endmodule

bind chip8_instruction_execute_unit_core c8eu_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
